// ----- rtl/core/i2cmbw_pkg.sv -----
package i2cmbw_pkg;

   // Transaction phases of the write engine.
   localparam logic [2:0] PH_IDLE  = 3'd0;
   localparam logic [2:0] PH_START = 3'd1;
   localparam logic [2:0] PH_BITS  = 3'd2;
   localparam logic [2:0] PH_ACK   = 3'd3;
   localparam logic [2:0] PH_STOP  = 3'd4;

   // Error codes reported with each tick.
   localparam logic [1:0] ERR_NONE    = 2'd0;
   localparam logic [1:0] ERR_ADDRESS = 2'd1;
   localparam logic [1:0] ERR_CONTROL = 2'd2;
   localparam logic [1:0] ERR_DATA    = 2'd3;

   // Byte slots in the order they go out on the bus.
   localparam logic [1:0] SLOT_ADDRESS = 2'd0;
   localparam logic [1:0] SLOT_CONTROL = 2'd1;
   localparam logic [1:0] SLOT_DATA    = 2'd2;

   // Sub-tick positions within a start, bit, acknowledge or stop sequence.
   localparam logic [1:0] SUB_FIRST  = 2'd0;
   localparam logic [1:0] SUB_SECOND = 2'd1;
   localparam logic [1:0] SUB_THIRD  = 2'd2;

   localparam logic [2:0] BIT_MSB = 3'd7;
   localparam logic [2:0] BIT_LSB = 3'd0;

   // Reset value of the device address register (address plus write bit).
   localparam logic [7:0] DEVICE_ADDRESS_RESET = 8'h78;

   // One timing tick of input.
   typedef struct packed {
      logic       request_valid;
      logic [7:0] control_byte;
      logic [7:0] data_byte;
      logic       sda_in;
   } req_type;

   // Bus levels and status for one tick.
   typedef struct packed {
      logic       scl;
      logic       sda_out;
      logic       sda_drive;
      logic       busy_res;
      logic       done_res;
      logic [1:0] error_code;
   } rsp_type;

endpackage

// ----- rtl/core/i2cmbw_step.sv -----
module i2cmbw_step (
   input  logic                clock,
   input  logic                reset,
   input  logic                step_en,
   input  logic [7:0]          device_address,
   input  i2cmbw_pkg::req_type req,
   output i2cmbw_pkg::rsp_type rsp
);

   logic [2:0] phase_ff, phase_in;
   logic [1:0] slot_ff, slot_in;
   logic [2:0] bit_ff, bit_in;
   logic [1:0] sub_ff, sub_in;
   logic [7:0] ctl_ff, ctl_in;
   logic [7:0] dat_ff, dat_in;
   logic [1:0] fail_ff, fail_in;
   logic       scl_ff, scl_in;
   logic       sda_ff, sda_in;

   logic       start_req;
   logic [2:0] cur_phase;
   logic [1:0] cur_slot;
   logic [2:0] cur_bit;
   logic [1:0] cur_sub;
   logic [7:0] cur_byte;
   logic       drive;
   logic       busy;
   logic       done;

   // A request taken while idle restarts the sequence from its first start tick.
   assign start_req = (phase_ff == i2cmbw_pkg::PH_IDLE) && req.request_valid;
   assign cur_phase = start_req ? i2cmbw_pkg::PH_START  : phase_ff;
   assign cur_slot  = start_req ? i2cmbw_pkg::SLOT_ADDRESS : slot_ff;
   assign cur_bit   = start_req ? i2cmbw_pkg::BIT_MSB   : bit_ff;
   assign cur_sub   = start_req ? i2cmbw_pkg::SUB_FIRST : sub_ff;

   // Byte being shifted out in the current slot.
   always_comb begin
      case (cur_slot)
         i2cmbw_pkg::SLOT_ADDRESS: cur_byte = device_address;
         i2cmbw_pkg::SLOT_CONTROL: cur_byte = ctl_ff;
         default:                  cur_byte = dat_ff;
      endcase
   end

   // Next state and line levels for this tick.
   always_comb begin
      phase_in = cur_phase;
      slot_in  = cur_slot;
      bit_in   = cur_bit;
      sub_in   = cur_sub;
      ctl_in   = start_req ? req.control_byte : ctl_ff;
      dat_in   = start_req ? req.data_byte : dat_ff;
      fail_in  = start_req ? i2cmbw_pkg::ERR_NONE : fail_ff;
      scl_in   = scl_ff;
      sda_in   = sda_ff;
      drive    = 1'b1;
      busy     = 1'b1;
      done     = 1'b0;
      unique case (cur_phase)
         i2cmbw_pkg::PH_IDLE: begin
            scl_in = 1'b1;
            sda_in = 1'b1;
            busy   = 1'b0;
         end
         i2cmbw_pkg::PH_START: begin
            case (cur_sub)
               i2cmbw_pkg::SUB_FIRST: begin
                  scl_in = 1'b1;
                  sda_in = 1'b1;
                  sub_in = i2cmbw_pkg::SUB_SECOND;
               end
               i2cmbw_pkg::SUB_SECOND: begin
                  scl_in = 1'b1;
                  sda_in = 1'b0;
                  sub_in = i2cmbw_pkg::SUB_THIRD;
               end
               default: begin
                  scl_in   = 1'b0;
                  sda_in   = 1'b0;
                  sub_in   = i2cmbw_pkg::SUB_FIRST;
                  bit_in   = i2cmbw_pkg::BIT_MSB;
                  phase_in = i2cmbw_pkg::PH_BITS;
               end
            endcase
         end
         i2cmbw_pkg::PH_BITS: begin
            sda_in = cur_byte[cur_bit];
            case (cur_sub)
               i2cmbw_pkg::SUB_FIRST: begin
                  scl_in = 1'b0;
                  sub_in = i2cmbw_pkg::SUB_SECOND;
               end
               i2cmbw_pkg::SUB_SECOND: begin
                  scl_in = 1'b1;
                  sub_in = i2cmbw_pkg::SUB_THIRD;
               end
               default: begin
                  scl_in = 1'b0;
                  sub_in = i2cmbw_pkg::SUB_FIRST;
                  if (cur_bit == i2cmbw_pkg::BIT_LSB) begin
                     phase_in = i2cmbw_pkg::PH_ACK;
                  end else begin
                     bit_in = cur_bit - 3'd1;
                  end
               end
            endcase
         end
         i2cmbw_pkg::PH_ACK: begin
            // SDA is released; the level shown repeats the last driven bit.
            drive = 1'b0;
            if (cur_sub == i2cmbw_pkg::SUB_FIRST) begin
               scl_in = 1'b1;
               if (req.sda_in) begin
                  case (cur_slot)
                     i2cmbw_pkg::SLOT_ADDRESS: fail_in = i2cmbw_pkg::ERR_ADDRESS;
                     i2cmbw_pkg::SLOT_CONTROL: fail_in = i2cmbw_pkg::ERR_CONTROL;
                     default:                  fail_in = i2cmbw_pkg::ERR_DATA;
                  endcase
               end
               sub_in = i2cmbw_pkg::SUB_SECOND;
            end else begin
               scl_in = 1'b0;
               sub_in = i2cmbw_pkg::SUB_FIRST;
               if ((fail_in != i2cmbw_pkg::ERR_NONE) ||
                   (cur_slot >= i2cmbw_pkg::SLOT_DATA)) begin
                  phase_in = i2cmbw_pkg::PH_STOP;
               end else begin
                  slot_in  = cur_slot + 2'd1;
                  bit_in   = i2cmbw_pkg::BIT_MSB;
                  phase_in = i2cmbw_pkg::PH_BITS;
               end
            end
         end
         default: begin
            // Stop condition; unused phase codes behave the same way.
            case (cur_sub)
               i2cmbw_pkg::SUB_FIRST: begin
                  scl_in = 1'b0;
                  sda_in = 1'b0;
                  sub_in = i2cmbw_pkg::SUB_SECOND;
               end
               i2cmbw_pkg::SUB_SECOND: begin
                  scl_in = 1'b1;
                  sda_in = 1'b0;
                  sub_in = i2cmbw_pkg::SUB_THIRD;
               end
               default: begin
                  scl_in   = 1'b1;
                  sda_in   = 1'b1;
                  sub_in   = i2cmbw_pkg::SUB_FIRST;
                  done     = 1'b1;
                  phase_in = i2cmbw_pkg::PH_IDLE;
               end
            endcase
         end
      endcase
   end

   // Engine state advances once per accepted tick.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= i2cmbw_pkg::PH_IDLE;
         slot_ff  <= i2cmbw_pkg::SLOT_ADDRESS;
         bit_ff   <= i2cmbw_pkg::BIT_MSB;
         sub_ff   <= i2cmbw_pkg::SUB_FIRST;
         ctl_ff   <= 8'h00;
         dat_ff   <= 8'h00;
         fail_ff  <= i2cmbw_pkg::ERR_NONE;
         scl_ff   <= 1'b1;
         sda_ff   <= 1'b1;
      end else if (step_en) begin
         phase_ff <= phase_in;
         slot_ff  <= slot_in;
         bit_ff   <= bit_in;
         sub_ff   <= sub_in;
         ctl_ff   <= ctl_in;
         dat_ff   <= dat_in;
         fail_ff  <= fail_in;
         scl_ff   <= scl_in;
         sda_ff   <= sda_in;
      end
   end

   assign rsp.scl        = scl_in;
   assign rsp.sda_out    = sda_in;
   assign rsp.sda_drive  = drive;
   assign rsp.busy_res   = busy;
   assign rsp.done_res   = done;
   assign rsp.error_code = fail_in;

endmodule

// ----- rtl/core/i2c_master_byte_write.sv -----
// I2C master byte-write engine. Each request is one timing tick and yields exactly one
// response with the SCL/SDA levels, drive enable, busy, done and error code for that
// tick. A tick carrying request_valid while idle starts a transaction: start condition,
// the device address, control byte and data byte each with an acknowledge slot, then a
// stop condition; a NACK skips the remaining bytes and reports the failed byte. The block
// takes one request per cycle while the response register is free or being emptied; a
// request is held in the input register, then the engine state update loads its response
// into the response register, and the single engine state update between them sets that
// rate. Write the device address register only while the engine is idle.
module i2c_master_byte_write (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  i2cmbw_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output i2cmbw_pkg::rsp_type rsp_data,
   input  logic                csr_wr_en,
   input  logic [7:0]          csr_wr_data
);

   logic [7:0]          addr_ff;
   logic                in_valid_ff;
   i2cmbw_pkg::req_type in_req_ff;
   logic                out_valid_ff;
   i2cmbw_pkg::rsp_type out_rsp_ff;
   i2cmbw_pkg::rsp_type step_rsp;
   logic                advance;

   // Device address register.
   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff <= i2cmbw_pkg::DEVICE_ADDRESS_RESET;
      end else if (csr_wr_en) begin
         addr_ff <= csr_wr_data;
      end
   end

   // A held request moves on when the response register is free or being emptied.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_req_ff <= req_data;
      end
   end

   i2cmbw_step u_step (
      .clock          (clock),
      .reset          (reset),
      .step_en        (advance),
      .device_address (addr_ff),
      .req            (in_req_ff),
      .rsp            (step_rsp)
   );

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_rsp_ff <= step_rsp;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_rsp_ff;

endmodule

// ----- dv/i2c_master_byte_write_test.sv -----
`timescale 1ns / 100ps

module i2c_master_byte_write_test;

   // Marks a transaction plan in which every acknowledge slot sees ACK.
   localparam logic [1:0] NACK_NONE = 2'd3;

   // One planned transaction of the directed table.
   typedef struct packed {
      logic [7:0] address;
      logic [7:0] control;
      logic [7:0] payload;
      logic [1:0] nack_slot;
      logic       sda_noise;
      logic       chatter;
      logic [1:0] idle_ticks;
      logic [1:0] want_error;
   } plan_row_type;

   // Shadow copy of the engine state.
   typedef struct {
      logic [2:0] phase;
      logic [1:0] slot;
      logic [2:0] bit_index;
      logic [1:0] sub;
      logic [7:0] control;
      logic [7:0] payload;
      logic [1:0] fail;
      logic       scl;
      logic       sda;
   } engine_state_type;

   localparam plan_row_type DIRECTED_PLAN [3] = '{
      '{8'h78, 8'h40, 8'h01, i2cmbw_pkg::SLOT_DATA, 1'b1, 1'b1, 2'd2,
        i2cmbw_pkg::ERR_DATA},
      '{8'hFF, 8'hFF, 8'hA5, i2cmbw_pkg::SLOT_ADDRESS, 1'b0, 1'b1, 2'd1,
        i2cmbw_pkg::ERR_ADDRESS},
      '{8'h00, 8'h00, 8'h5A, i2cmbw_pkg::SLOT_CONTROL, 1'b1, 1'b0, 2'd0,
        i2cmbw_pkg::ERR_CONTROL}
   };

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   i2cmbw_pkg::req_type req_data = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   i2cmbw_pkg::rsp_type rsp_data;
   logic                csr_wr_en = 1'b0;
   logic [7:0]          csr_wr_data = 8'h00;

   engine_state_type    engine;
   logic [7:0]          device_address;
   i2cmbw_pkg::rsp_type expected_bus [$];
   int                  mismatch_count = 0;
   int                  send_idle_pct = 0;
   int                  recv_stall_pct = 0;

   i2c_master_byte_write dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Hard limit on simulated time.
   initial begin
      #4000000;
      $display("i2c_master_byte_write_test failed");
      $finish;
   end

   // Prints one line per mismatch and counts it.
   task automatic flag_mismatch(input string what, input logic [7:0] got,
                                input logic [7:0] want);
      $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   task automatic compare_bus(input i2cmbw_pkg::rsp_type got,
                              input i2cmbw_pkg::rsp_type want);
      if (got.scl !== want.scl)
         flag_mismatch("scl", 8'(got.scl), 8'(want.scl));
      if (got.sda_out !== want.sda_out)
         flag_mismatch("sda_out", 8'(got.sda_out), 8'(want.sda_out));
      if (got.sda_drive !== want.sda_drive)
         flag_mismatch("sda_drive", 8'(got.sda_drive), 8'(want.sda_drive));
      if (got.busy_res !== want.busy_res)
         flag_mismatch("busy_res", 8'(got.busy_res), 8'(want.busy_res));
      if (got.done_res !== want.done_res)
         flag_mismatch("done_res", 8'(got.done_res), 8'(want.done_res));
      if (got.error_code !== want.error_code)
         flag_mismatch("error_code", 8'(got.error_code), 8'(want.error_code));
   endtask

   // Returns the byte that goes out in the current slot.
   function automatic logic [7:0] slot_byte();
      if (engine.slot == i2cmbw_pkg::SLOT_ADDRESS) return device_address;
      if (engine.slot == i2cmbw_pkg::SLOT_CONTROL) return engine.control;
      return engine.payload;
   endfunction

   // Moves the shadow engine by one tick and returns the bus levels it drives.
   function automatic i2cmbw_pkg::rsp_type advance_engine(input i2cmbw_pkg::req_type tick);
      i2cmbw_pkg::rsp_type out;
      logic                drive;
      logic                done;
      logic [7:0]          shift_byte;
      drive = 1'b1;
      done  = 1'b0;
      if (engine.phase == i2cmbw_pkg::PH_IDLE) begin
         if (!tick.request_valid) begin
            engine.scl = 1'b1;
            engine.sda = 1'b1;
            out.scl = 1'b1;
            out.sda_out = 1'b1;
            out.sda_drive = 1'b1;
            out.busy_res = 1'b0;
            out.done_res = 1'b0;
            out.error_code = engine.fail;
            return out;
         end
         engine.control   = tick.control_byte;
         engine.payload   = tick.data_byte;
         engine.fail      = i2cmbw_pkg::ERR_NONE;
         engine.slot      = i2cmbw_pkg::SLOT_ADDRESS;
         engine.bit_index = i2cmbw_pkg::BIT_MSB;
         engine.sub       = i2cmbw_pkg::SUB_FIRST;
         engine.phase     = i2cmbw_pkg::PH_START;
      end

      case (engine.phase)
         i2cmbw_pkg::PH_START: begin
            if (engine.sub == i2cmbw_pkg::SUB_FIRST) begin
               engine.scl = 1'b1;
               engine.sda = 1'b1;
               engine.sub = i2cmbw_pkg::SUB_SECOND;
            end else if (engine.sub == i2cmbw_pkg::SUB_SECOND) begin
               engine.scl = 1'b1;
               engine.sda = 1'b0;
               engine.sub = i2cmbw_pkg::SUB_THIRD;
            end else begin
               engine.scl = 1'b0;
               engine.sda = 1'b0;
               engine.sub = i2cmbw_pkg::SUB_FIRST;
               engine.bit_index = i2cmbw_pkg::BIT_MSB;
               engine.phase = i2cmbw_pkg::PH_BITS;
            end
         end
         i2cmbw_pkg::PH_BITS: begin
            shift_byte = slot_byte();
            engine.sda = shift_byte[engine.bit_index];
            if (engine.sub == i2cmbw_pkg::SUB_FIRST) begin
               engine.scl = 1'b0;
               engine.sub = i2cmbw_pkg::SUB_SECOND;
            end else if (engine.sub == i2cmbw_pkg::SUB_SECOND) begin
               engine.scl = 1'b1;
               engine.sub = i2cmbw_pkg::SUB_THIRD;
            end else begin
               engine.scl = 1'b0;
               engine.sub = i2cmbw_pkg::SUB_FIRST;
               if (engine.bit_index == i2cmbw_pkg::BIT_LSB) engine.phase = i2cmbw_pkg::PH_ACK;
               else engine.bit_index = engine.bit_index - 3'd1;
            end
         end
         i2cmbw_pkg::PH_ACK: begin
            drive = 1'b0;
            if (engine.sub == i2cmbw_pkg::SUB_FIRST) begin
               engine.scl = 1'b1;
               if (tick.sda_in) begin
                  case (engine.slot)
                     i2cmbw_pkg::SLOT_ADDRESS: engine.fail = i2cmbw_pkg::ERR_ADDRESS;
                     i2cmbw_pkg::SLOT_CONTROL: engine.fail = i2cmbw_pkg::ERR_CONTROL;
                     default:                  engine.fail = i2cmbw_pkg::ERR_DATA;
                  endcase
               end
               engine.sub = i2cmbw_pkg::SUB_SECOND;
            end else begin
               engine.scl = 1'b0;
               engine.sub = i2cmbw_pkg::SUB_FIRST;
               if (engine.fail != i2cmbw_pkg::ERR_NONE ||
                   engine.slot >= i2cmbw_pkg::SLOT_DATA) begin
                  engine.phase = i2cmbw_pkg::PH_STOP;
               end else begin
                  engine.slot = engine.slot + 2'd1;
                  engine.bit_index = i2cmbw_pkg::BIT_MSB;
                  engine.phase = i2cmbw_pkg::PH_BITS;
               end
            end
         end
         default: begin
            if (engine.sub == i2cmbw_pkg::SUB_FIRST) begin
               engine.scl = 1'b0;
               engine.sda = 1'b0;
               engine.sub = i2cmbw_pkg::SUB_SECOND;
            end else if (engine.sub == i2cmbw_pkg::SUB_SECOND) begin
               engine.scl = 1'b1;
               engine.sda = 1'b0;
               engine.sub = i2cmbw_pkg::SUB_THIRD;
            end else begin
               engine.scl = 1'b1;
               engine.sda = 1'b1;
               engine.sub = i2cmbw_pkg::SUB_FIRST;
               done = 1'b1;
               engine.phase = i2cmbw_pkg::PH_IDLE;
            end
         end
      endcase

      out.scl = engine.scl;
      out.sda_out = engine.sda;
      out.sda_drive = drive;
      out.busy_res = 1'b1;
      out.done_res = done;
      out.error_code = engine.fail;
      return out;
   endfunction

   // Offers one tick request, with random idle gaps, and predicts it once accepted.
   task automatic send_tick(input i2cmbw_pkg::req_type tick);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= tick;
      do @(posedge clock); while (!req_ready);
      expected_bus.push_back(advance_engine(tick));
   endtask

   // Idle ticks with random content on the ignored fields.
   task automatic send_idle_ticks(input int count);
      i2cmbw_pkg::req_type tick;
      repeat (count) begin
         tick.request_valid = 1'b0;
         tick.control_byte  = 8'($urandom);
         tick.data_byte     = 8'($urandom);
         tick.sda_in        = 1'($urandom_range(1));
         send_tick(tick);
      end
   endtask

   // Drives one whole transaction, answering each acknowledge slot from the plan.
   task automatic run_transaction(input logic [7:0] control, input logic [7:0] payload,
                                  input logic [1:0] nack_slot, input logic sda_noise,
                                  input logic chatter);
      i2cmbw_pkg::req_type tick;
      tick.request_valid = 1'b1;
      tick.control_byte  = control;
      tick.data_byte     = payload;
      tick.sda_in        = sda_noise ? 1'($urandom_range(1)) : 1'b0;
      send_tick(tick);
      while (engine.phase != i2cmbw_pkg::PH_IDLE) begin
         tick.request_valid = chatter ? 1'($urandom_range(1)) : 1'b0;
         tick.control_byte  = 8'($urandom);
         tick.data_byte     = 8'($urandom);
         if (engine.phase == i2cmbw_pkg::PH_ACK && engine.sub == i2cmbw_pkg::SUB_FIRST)
            tick.sda_in = (engine.slot == nack_slot);
         else
            tick.sda_in = sda_noise ? 1'($urandom_range(1)) : 1'b0;
         send_tick(tick);
      end
   endtask

   // Stops sending and waits until every expected tick has come back.
   task automatic drain_bus();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_bus.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Writes the device address once the engine has gone quiet.
   task automatic set_device_address(input logic [7:0] value);
      drain_bus();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      device_address = value;
   endtask

   // Receiver side: random backpressure on the result channel.
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Every accepted tick result is checked against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_bus.size() == 0)
            flag_mismatch("unexpected result", 8'(rsp_data), 8'h00);
         else
            compare_bus(rsp_data, expected_bus.pop_front());
      end
   end

   initial begin
      plan_row_type row;
      logic [1:0]   nack_slot;
      logic [7:0]   control;

      engine.phase = i2cmbw_pkg::PH_IDLE;
      engine.slot = i2cmbw_pkg::SLOT_ADDRESS;
      engine.bit_index = i2cmbw_pkg::BIT_MSB;
      engine.sub = i2cmbw_pkg::SUB_FIRST;
      engine.control = 8'h00;
      engine.payload = 8'h00;
      engine.fail = i2cmbw_pkg::ERR_NONE;
      engine.scl = 1'b1;
      engine.sda = 1'b1;
      device_address = i2cmbw_pkg::DEVICE_ADDRESS_RESET;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed transactions: every byte refused in turn, extreme bytes and addresses.
      for (int i = 0; i < 3; i++) begin
         row = DIRECTED_PLAN[i];
         if (row.address != device_address) set_device_address(row.address);
         send_idle_ticks(row.idle_ticks);
         run_transaction(row.control, row.payload, row.nack_slot, row.sda_noise, row.chatter);
         if (engine.fail !== row.want_error)
            flag_mismatch("planned error code", 8'(engine.fail), 8'(row.want_error));
      end
      send_idle_ticks(3);

      // Random transactions under each idling pattern and several addresses.
      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
            default: begin send_idle_pct = 18; recv_stall_pct = 18; end
         endcase
         case (p)
            0: set_device_address(8'hFF);
            1: set_device_address(8'h00);
            2: set_device_address(i2cmbw_pkg::DEVICE_ADDRESS_RESET);
            default: set_device_address(8'($urandom));
         endcase
         if ($urandom_range(3) == 0) send_idle_ticks($urandom_range(1, 3));
         // The first pattern always runs a transaction that every slot acknowledges.
         nack_slot = (p == 0) ? NACK_NONE : 2'($urandom_range(3));
         case ($urandom_range(3))
            0: control = 8'h00;
            1: control = 8'h40;
            default: control = 8'($urandom);
         endcase
         run_transaction(control, 8'($urandom), nack_slot, 1'($urandom_range(1)),
                         1'($urandom_range(1)));
      end

      drain_bus();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("i2c_master_byte_write_test passed");
      else
         $display("i2c_master_byte_write_test failed");
      $finish;
   end

endmodule
